/* rtl/assert_macros.svh */
// Assertion macros shared by the serial line assembler RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while out of reset.
`define SLA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks an implication on every rising clock edge while out of reset.
`define SLA_ASSERT_IMPL(label, ante, cons, msg) \
  `SLA_ASSERT(label, (ante) |-> (cons), msg)

`endif

/* rtl/sla_pkg.sv */
// Package for the serial line assembler: sizes, character codes and types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sla_pkg;

  // Number of entries in the line store.
  localparam int LINE_DEPTH = 32;
  // Address width of the line store; also holds the largest fill count.
  localparam int ADDR_W = $clog2(LINE_DEPTH);
  // Width of the configuration register.
  localparam int CFG_W = 8;

  localparam logic [CFG_W-1:0] MAX_OUT_LEN_RST = CFG_W'(32);

  // Character codes.
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;

  // One input transaction.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       overrun_error;
  } sla_in_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] out_char;
    logic       line_end;
  } sla_out_t;

  // Controller states.
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_REPLAY
  } sla_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;   // append the input byte to the line store
    logic clear;   // empty the line store
    logic start;   // latch the line length and begin replay
    logic load;    // load the next result into the output register
  } sla_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_cr;     // input byte is a carriage return
    logic is_lf;     // input byte is a line feed
    logic overrun;   // input is flagged as a receiver overrun
    logic full;      // line store holds its maximum number of bytes
    logic fits;      // held length is below the configured maximum
    logic at_end;    // replay pointer has reached the terminator
    logic out_free;  // output register can take a new result
  } sla_status_t;

endpackage

/* rtl/sla_ctrl.sv */
// Controller of the serial line assembler: accepts bytes and sequences replay.
// Depends on sla_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sla_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sla_pkg::sla_status_t status,
  output sla_pkg::sla_cmd_t    cmd
);

  sla_pkg::sla_state_t state_r;
  sla_pkg::sla_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sla_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      sla_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (status.overrun) begin
            cmd.clear = 1'b1;
          end else if (status.is_lf) begin
            // A line that fits is replayed; a long one is dropped.
            if (status.fits) begin
              cmd.start = 1'b1;
              state_nxt = sla_pkg::ST_REPLAY;
            end else begin
              cmd.clear = 1'b1;
            end
          end else if (!status.is_cr) begin
            // An ordinary byte is stored, or empties a full store.
            if (status.full) begin
              cmd.clear = 1'b1;
            end else begin
              cmd.store = 1'b1;
            end
          end
        end
      end
      sla_pkg::ST_REPLAY: begin
        if (status.out_free) begin
          cmd.load = 1'b1;
          if (status.at_end) begin
            state_nxt = sla_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sla_pkg::ST_IDLE;
      end
    endcase
  end

  // An input transaction is only ever taken while idle.
  `SLA_ASSERT_IMPL(a_accept_idle, in_valid && !in_stall, state_r == sla_pkg::ST_IDLE,
    "input accepted outside idle")
  // Replay starts only after an accepted line feed.
  `SLA_ASSERT_IMPL(a_replay_cause,
    state_r == sla_pkg::ST_REPLAY && $past(state_r) == sla_pkg::ST_IDLE,
    $past(in_valid && status.is_lf && !status.overrun),
    "replay started without a line feed")
  // Replay does not advance while the output register is blocked.
  `SLA_ASSERT(a_replay_hold,
    state_r == sla_pkg::ST_REPLAY && !status.out_free |=> state_r == sla_pkg::ST_REPLAY,
    "replay left while output blocked")

endmodule

/* rtl/sla_dpath.sv */
// Datapath of the serial line assembler: line store, counters, output register.
// Depends on sla_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sla_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sla_pkg::sla_in_t             in_data,
  input  logic                         cfg_wr_en,
  input  logic [sla_pkg::CFG_W-1:0]    cfg_wr_data,
  input  sla_pkg::sla_cmd_t            cmd,
  output sla_pkg::sla_status_t         status,
  output logic                         out_valid,
  input  logic                         out_stall,
  output sla_pkg::sla_out_t            out_data
);

  logic [7:0]                  line_store [sla_pkg::LINE_DEPTH];
  logic [7:0]                  rd_data_r;
  logic [sla_pkg::ADDR_W-1:0]  fill_r;
  logic [sla_pkg::ADDR_W-1:0]  fill_nxt;
  logic [sla_pkg::ADDR_W-1:0]  len_r;
  logic [sla_pkg::ADDR_W-1:0]  ptr_r;
  logic [sla_pkg::ADDR_W-1:0]  ptr_nxt;
  logic [sla_pkg::CFG_W-1:0]   max_len_r;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  sla_pkg::sla_out_t           out_data_r;

  // Status decode.
  always_comb begin
    status.is_cr    = (in_data.rx_byte == sla_pkg::CH_CR);
    status.is_lf    = (in_data.rx_byte == sla_pkg::CH_LF);
    status.overrun  = in_data.overrun_error;
    status.full     = (fill_r == sla_pkg::ADDR_W'(sla_pkg::LINE_DEPTH - 1));
    status.fits     = (sla_pkg::CFG_W'(fill_r) < max_len_r);
    status.at_end   = (ptr_r == len_r);
    status.out_free = !out_valid_r || !out_stall;
  end

  // Fill count and replay pointer next values.
  always_comb begin
    fill_nxt = fill_r;
    if (cmd.clear || cmd.start) begin
      fill_nxt = '0;
    end else if (cmd.store) begin
      fill_nxt = fill_r + sla_pkg::ADDR_W'(1);
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.start) begin
      ptr_nxt = '0;
    end else if (cmd.load) begin
      ptr_nxt = status.at_end ? '0 : ptr_r + sla_pkg::ADDR_W'(1);
    end
  end

  // Output valid next value: set on load, cleared once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      ptr_r       <= '0;
      max_len_r   <= sla_pkg::MAX_OUT_LEN_RST;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
    end
  end

  // Line length is captured when a replay starts.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      len_r <= fill_r;
    end
  end

  // Line store. The read port always fetches the entry at the next pointer,
  // so rd_data_r holds the entry at the current pointer.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      line_store[fill_r] <= in_data.rx_byte;
    end
    rd_data_r <= line_store[ptr_nxt];
  end

  // Output register: a stored byte, or the terminator at the end of the line.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r.out_char <= status.at_end ? sla_pkg::CH_NUL : rd_data_r;
      out_data_r.line_end <= status.at_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The controller loads only when the output register can take a result.
  `SLA_ASSERT_IMPL(a_load_free, cmd.load, status.out_free, "load into a busy output")
  // The replay pointer never passes the latched line length.
  `SLA_ASSERT(a_ptr_bound, ptr_r <= len_r || ptr_r == '0, "replay pointer past line end")
  // Loading at the end of the line presents the terminator.
  `SLA_ASSERT(a_term_out, cmd.load && status.at_end |=> out_valid_r && out_data_r.line_end
    && out_data_r.out_char == sla_pkg::CH_NUL, "terminator not presented")

endmodule

/* rtl/serial_line_assembler_unit.sv */
// Serial line assembler: a byte is taken every cycle while idle. A line feed that completes a
// fitting line of N bytes stalls the input while the N bytes and a terminator are replayed, one
// result per cycle through the registered read port while the output does not stall; the first
// result is loaded in the replay state and shown from the output register. Synchronous
// active-low reset empties the line and sets max_out_len to 32; the store is not cleared, since
// only entries below the fill count are ever read. Depends on sla_pkg, sla_ctrl and sla_dpath.
`timescale 1ns / 1ps

module serial_line_assembler_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  sla_pkg::sla_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output sla_pkg::sla_out_t          out_data,
  input  logic                       cfg_wr_en,
  input  logic [sla_pkg::CFG_W-1:0]  cfg_wr_data
);

  sla_pkg::sla_cmd_t    cmd;
  sla_pkg::sla_status_t status;

  // Sequencer.
  sla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Line store and output register.
  sla_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
